FILE: design/mf3_pkg.sv
package mf3_pkg;

  // Payload and register widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned CFGW_W  = 12;
  localparam int unsigned CFGH_W  = 13;
  localparam int unsigned CFG_D_W = 13;
  localparam int unsigned CFG_I_W = 1;

  // Window geometry
  localparam int unsigned WIN      = 3;
  localparam int unsigned NTAPS    = WIN * WIN;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned MED_RANK = NTAPS / 2;

  // Frame limits
  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Register indexes
  localparam logic [CFG_I_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_I_W-1:0] REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN-1:0]   col_t;
  typedef pix_t [NTAPS-1:0] win_t;

  // Position and end-of-frame flag that travel with a result
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } meta_t;

endpackage

FILE: design/mf3_col_cell.sv
module mf3_col_cell
  import mf3_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  col_t col_i,
  output col_t col_o
);

  col_t col_q;

  // Take the neighbor's column on every shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

FILE: design/mf3_line_buf.sv
module mf3_line_buf
  import mf3_pkg::*;
#(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [2*PIX_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [2*PIX_W-1:0] rd_data_o
);

  // One word per column: {older row, newer row}
  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/mf3_median.sv
module mf3_median
  import mf3_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  win_t  win_i,
  input  meta_t meta_i,
  output logic  valid_o,
  input  logic  ready_i,
  output pix_t  pixel_o,
  output meta_t meta_o
);

  // Stage 1: pairwise order matrix, stage 2: rank count and pick
  logic                   s1_valid_q, s2_valid_q;
  win_t                   s1_win_q;
  meta_t                  s1_meta_q, s2_meta_q;
  logic [NTAPS-1:0][NTAPS-1:0] lt_d, lt_q;
  pix_t                   med_d, s2_pix_q;
  logic                   s1_ready, s2_ready;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  // Element j sorts ahead of i when smaller, or equal with lower index
  always_comb begin
    for (int i = 0; i < NTAPS; i++) begin
      for (int j = 0; j < NTAPS; j++) begin
        if (j < i) begin
          lt_d[i][j] = (win_i[j] <= win_i[i]);
        end else if (j > i) begin
          lt_d[i][j] = (win_i[j] < win_i[i]);
        end else begin
          lt_d[i][j] = 1'b0;
        end
      end
    end
  end

  // Pick the element whose rank is the middle one
  always_comb begin
    med_d = '0;
    for (int i = 0; i < NTAPS; i++) begin
      if (RANK_W'($countones(lt_q[i])) == RANK_W'(MED_RANK)) begin
        med_d = s1_win_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers: load when the stage advances
  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_win_q  <= win_i;
      s1_meta_q <= meta_i;
      lt_q      <= lt_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_pix_q  <= med_d;
      s2_meta_q <= s1_meta_q;
    end
  end

  assign valid_o = s2_valid_q;
  assign pixel_o = s2_pix_q;
  assign meta_o  = s2_meta_q;

endmodule

FILE: design/median_filter_3x3.sv
// 3x3 median filter over a raster-order 8-bit grayscale stream. One pixel is
// taken per clock unless in_ready_o stalls, and one median per interior
// position is produced, tagged with the row and column of the centre pixel;
// frame_done_o marks the last interior result of the frame. Border positions
// produce no item; results come from a registered output. The rate is set by
// the line store, whose single read and single write port each serve one
// pixel per cycle. Frame size comes from two registers, width (index 0,
// saturated into 3..MAX_WIDTH) and height (index 1, saturated into 3..4096),
// to be written only while the block is idle; the block does not enforce it.
module median_filter_3x3
  import mf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PIX_W-1:0]   in_pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PIX_W-1:0]   out_pixel_o,
  output logic [ROW_W-1:0]   out_row_o,
  output logic [COL_W-1:0]   out_col_o,
  output logic               frame_done_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_I_W-1:0] cfg_index_i,
  input  logic [CFG_D_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = AW + 1;

  // Configuration
  logic [CFGW_W-1:0] cfg_width_q;
  logic [CFGH_W-1:0] cfg_height_q;
  logic [WW-1:0]     w_eff;
  logic [CFGH_W-1:0] h_eff;

  // Position counters
  logic [AW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [WW-1:0]     col_inc;
  logic [CFGH_W-1:0] row_inc;

  // Stage A: accepted pixel waiting for its line store read
  logic              a_valid_q;
  pix_t              a_pix_q;
  logic [AW-1:0]     a_col_q;
  logic              a_emit_q;
  meta_t             a_meta_q;
  logic              emit_d;
  meta_t             meta_d;

  // Stage B: window holding a result candidate
  logic              b_valid_q;
  meta_t             b_meta_q;
  logic              b_ready, a_fire, in_fire;

  logic [2*PIX_W-1:0] rd_data;
  col_t               col_new;
  col_t [WIN:0]       win_col;
  win_t               win;

  logic               med_ready;
  meta_t              med_meta;

  assign cfg_ready_o = 1'b1;

  // Saturate the frame size into the legal range
  always_comb begin
    if (cfg_width_q < CFGW_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(cfg_width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_q);
    end
    if (cfg_height_q < CFGH_W'(MIN_DIM)) begin
      h_eff = CFGH_W'(MIN_DIM);
    end else if (32'(cfg_height_q) > MAX_HEIGHT) begin
      h_eff = CFGH_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFGW_W'(640);
      cfg_height_q <= CFGH_W'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  cfg_width_q  <= cfg_data_i[CFGW_W-1:0];
        REG_HEIGHT: cfg_height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Handshake: each stage moves when the next one has room
  assign b_ready    = !b_valid_q || med_ready;
  assign a_fire     = a_valid_q && b_ready;
  assign in_ready_o = !a_valid_q || b_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // Advance column and row, wrap at row and frame end
  always_comb begin
    col_inc = WW'(col_q) + WW'(1);
    row_inc = CFGH_W'(row_q) + CFGH_W'(1);
    col_d   = col_inc[AW-1:0];
    row_d   = row_q;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  // Interior test and tag for this pixel
  always_comb begin
    emit_d = (row_q >= ROW_W'(2)) && (col_q >= AW'(2)) &&
             (CFGH_W'(row_q) < h_eff) && (WW'(col_q) < w_eff);
    meta_d.row  = row_q - ROW_W'(1);
    meta_d.col  = COL_W'(WW'(col_q) - WW'(1));
    meta_d.done = (CFGH_W'(row_q) == h_eff - CFGH_W'(1)) &&
                  (WW'(col_q) == w_eff - WW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (a_fire) begin
        b_valid_q <= a_emit_q;
      end else if (med_ready) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  // Hold the pixel and its tag while the line store read completes
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_pix_q  <= in_pixel_i;
      a_col_q  <= col_q;
      a_emit_q <= emit_d;
      a_meta_q <= meta_d;
    end
    if (a_fire) begin
      b_meta_q <= a_meta_q;
    end
  end

  // Two previous rows, one word per column
  mf3_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (a_fire),
    .wr_addr_i (a_col_q),
    .wr_data_i ({rd_data[PIX_W-1:0], a_pix_q}),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data)
  );

  // New column: top row, middle row, incoming pixel
  assign col_new[0] = rd_data[2*PIX_W-1:PIX_W];
  assign col_new[1] = rd_data[PIX_W-1:0];
  assign col_new[2] = a_pix_q;

  // Feed the new column in at the right end of the chain
  assign win_col[WIN] = col_new;

  // Window columns as a chain of cells, newest on the right
  for (genvar k = 0; k < WIN; k++) begin : g_cell
    mf3_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (a_fire),
      .col_i   (win_col[k+1]),
      .col_o   (win_col[k])
    );
  end

  // Flatten to [row][col] order
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        win[r*WIN + c] = win_col[c][r];
      end
    end
  end

  mf3_median u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid_q),
    .ready_o (med_ready),
    .win_i   (win),
    .meta_i  (b_meta_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .pixel_o (out_pixel_o),
    .meta_o  (med_meta)
  );

  assign out_row_o    = med_meta.row;
  assign out_col_o    = med_meta.col;
  assign frame_done_o = med_meta.done;

endmodule

FILE: sim/median_filter_3x3_tb.sv
module median_filter_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int unsigned LINE_W        = 2048;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned RANDOM_PIXELS = 200;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum int {PIX_RANDOM, PIX_LEVELS, PIX_RAILS, PIX_RAMP} pix_style_e;
  typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_e;

  typedef struct packed {
    pix_t             pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } median_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  pix_t               in_pixel    = '0;
  logic               out_ready   = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic [CFG_I_W-1:0] cfg_index   = REG_WIDTH;
  logic [CFG_D_W-1:0] cfg_data    = '0;

  logic               in_ready_o;
  logic               out_valid_o;
  pix_t               out_pixel_o;
  logic [ROW_W-1:0]   out_row_o;
  logic [COL_W-1:0]   out_col_o;
  logic               frame_done_o;
  logic               cfg_ready_o;

  // Predicted filter state, mirrors the block's geometry and line stores
  logic [CFGW_W-1:0]  cfg_width  = 12'd640;
  logic [CFGH_W-1:0]  cfg_height = 13'd480;
  pix_t               mid_line [LINE_W] = '{default: '0};
  pix_t               top_line [LINE_W] = '{default: '0};
  pix_t               window [WIN][WIN] = '{default: '{default: '0}};
  int unsigned        col_cnt = 0;
  int unsigned        row_cnt = 0;

  pix_t               pixels_to_send [$];
  median_t            pending_medians [$];

  int unsigned        send_gap_pct   = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        errors          = 0;
  int unsigned        pixels_in       = 0;
  int unsigned        medians_checked = 0;
  int unsigned        frames_closed   = 0;
  int unsigned        cfg_writes      = 0;

  median_filter_3x3 #(
    .MAX_WIDTH(LINE_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_pixel_o (out_pixel_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_done_o(frame_done_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned sat_dim(int unsigned v, int unsigned hi);
    return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
  endfunction

  // Pick the tap whose rank range covers the middle position
  function automatic pix_t window_median();
    pix_t        taps [NTAPS];
    int unsigned lt;
    int unsigned eq;
    foreach (window[r, c]) taps[r*WIN + c] = window[r][c];
    for (int i = 0; i < NTAPS; i++) begin
      lt = 0;
      eq = 0;
      for (int j = 0; j < NTAPS; j++) begin
        if (taps[j] < taps[i]) lt++;
        else if (taps[j] == taps[i]) eq++;
      end
      if (lt <= MED_RANK && lt + eq > MED_RANK) return taps[i];
    end
    return taps[0];
  endfunction

  // Advance the predicted filter by one accepted pixel
  function automatic void filter_pixel(pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned ci;
    pix_t        up2;
    pix_t        up1;
    median_t     res;
    w   = sat_dim(cfg_width, LINE_W);
    h   = sat_dim(cfg_height, MAX_HEIGHT);
    ci  = (col_cnt < LINE_W) ? col_cnt : LINE_W - 1;
    up2 = top_line[ci];
    up1 = mid_line[ci];
    for (int r = 0; r < WIN; r++) begin
      for (int k = 0; k < WIN - 1; k++) window[r][k] = window[r][k+1];
    end
    window[0][WIN-1] = up2;
    window[1][WIN-1] = up1;
    window[2][WIN-1] = px;
    top_line[ci] = up1;
    mid_line[ci] = px;
    if (row_cnt >= 2 && col_cnt >= 2 && row_cnt < h && col_cnt < w) begin
      res.pixel = window_median();
      res.row   = ROW_W'(row_cnt - 1);
      res.col   = COL_W'(col_cnt - 1);
      res.done  = (row_cnt == h - 1) && (col_cnt == w - 1);
      pending_medians.push_back(res);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  // Pixels still needed to bring the predicted counters back to frame start
  function automatic int unsigned pixels_left();
    int unsigned c;
    int unsigned r;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    c = col_cnt;
    r = row_cnt;
    w = sat_dim(cfg_width, LINE_W);
    h = sat_dim(cfg_height, MAX_HEIGHT);
    n = 0;
    while (c != 0 || r != 0) begin
      c++;
      n++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
    end
    return n;
  endfunction

  // Mostly small frame sizes, now and then an undersized register value
  function automatic int unsigned pick_dim(int unsigned hi);
    return ($urandom_range(4) == 0) ? $urandom_range(2) : $urandom_range(hi, MIN_DIM);
  endfunction

  task automatic push_pixels(int unsigned n, pix_style_e style);
    pix_t p;
    for (int unsigned i = 0; i < n; i++) begin
      case (style)
        PIX_LEVELS: p = pix_t'($urandom_range(3) * 85);
        PIX_RAILS:  p = $urandom_range(1) ? 8'hFF : 8'h00;
        PIX_RAMP:   p = pix_t'(i);
        default:    p = pix_t'($urandom_range(255));
      endcase
      pixels_to_send.push_back(p);
    end
  endtask

  // Wait until every pixel is taken and every median is back, then let the pipe empty
  task automatic settle();
    while (pixels_to_send.size() != 0 || in_valid || pending_medians.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_I_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_D_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_WIDTH) cfg_width = CFGW_W'(value);
    else cfg_height = CFGH_W'(value);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_flow(flow_e f);
    case (f)
      FLOW_SEND_GAPS: begin
        send_gap_pct   = 57;
        recv_stall_pct = 0;
      end
      FLOW_RECV_STALLS: begin
        send_gap_pct   = 0;
        recv_stall_pct = 57;
      end
      FLOW_BOTH: begin
        send_gap_pct   = 22;
        recv_stall_pct = 22;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Pixel driver: predict on acceptance, then load the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_pixel <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        filter_pixel(in_pixel);
        pixels_in++;
      end
      if (!in_valid || in_ready_o) begin
        if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_pixel <= pixels_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted item with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : check_medians
    median_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (pending_medians.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected median %0d at row %0d col %0d done %0b",
                     out_pixel_o, out_row_o, out_col_o, frame_done_o);
        end else begin
          want = pending_medians.pop_front();
          medians_checked++;
          if (want.done) frames_closed++;
          if (out_pixel_o !== want.pixel || out_row_o !== want.row ||
              out_col_o !== want.col || frame_done_o !== want.done) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("bad median: expected pix %0d row %0d col %0d done %0b,",
                       want.pixel, want.row, want.col, want.done,
                       " got pix %0d row %0d col %0d done %0b",
                       out_pixel_o, out_row_o, out_col_o, frame_done_o);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hang detection: no item moved on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timed out after %0d idle cycles", QUIET_LIMIT);
    $display("median_filter_3x3: mismatch");
    $finish;
  end

  initial begin : stimulus
    pix_t        directed [27];
    int unsigned random_pixels;
    int unsigned frame_no;
    int unsigned full;
    int unsigned cut;
    pix_style_e  style;

    directed = '{
      8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd7,   8'd1,   8'd9,   8'd7,   8'd1,   8'd9,   8'd7,   8'd1,   8'd9
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: one full row and the start of the next, then shrink
    // the width so the row wraps and close the frame on the third row
    set_flow(FLOW_BOTH);
    push_pixels(640 + 8, PIX_RANDOM);
    settle();
    cfg_write(REG_WIDTH, 8);
    cfg_write(REG_HEIGHT, 3);
    push_pixels(pixels_left(), PIX_RANDOM);

    // Smallest frame from undersized register values: rails, flat, ties
    settle();
    set_flow(FLOW_FREE);
    cfg_write(REG_WIDTH, 1);
    cfg_write(REG_HEIGHT, 2);
    foreach (directed[i]) pixels_to_send.push_back(directed[i]);

    // Width register all ones: run part of a row, then narrow and finish
    settle();
    set_flow(FLOW_SEND_GAPS);
    cfg_write(REG_WIDTH, 4095);
    cfg_write(REG_HEIGHT, 3);
    push_pixels(50, PIX_RANDOM);
    settle();
    cfg_write(REG_WIDTH, 9);
    push_pixels(pixels_left(), PIX_RANDOM);

    // Width zero, height register all ones: run twenty rows, then cut short
    settle();
    set_flow(FLOW_RECV_STALLS);
    cfg_write(REG_WIDTH, 0);
    cfg_write(REG_HEIGHT, 8191);
    push_pixels(3 * 20, PIX_LEVELS);
    settle();
    cfg_write(REG_HEIGHT, 3);
    push_pixels(pixels_left(), PIX_LEVELS);

    // Geometry changes inside a frame: grow width, shrink past the column, drop height
    settle();
    set_flow(FLOW_FREE);
    cfg_write(REG_WIDTH, 8);
    cfg_write(REG_HEIGHT, 6);
    push_pixels(48 + 26, PIX_RAMP);
    settle();
    cfg_write(REG_WIDTH, 12);
    push_pixels(13, PIX_RAILS);
    settle();
    cfg_write(REG_WIDTH, 2);
    push_pixels(1, PIX_RANDOM);
    settle();
    cfg_write(REG_HEIGHT, 4);
    push_pixels(pixels_left(), PIX_RANDOM);

    // Random frames, streamed back to back unless the geometry changes
    random_pixels = 0;
    frame_no = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      set_flow(flow_e'(frame_no % 4));
      style = pix_style_e'($urandom_range(3));
      if ($urandom_range(3) == 0) begin
        settle();
        cfg_write(REG_WIDTH, pick_dim(14));
        cfg_write(REG_HEIGHT, pick_dim(9));
      end
      full = sat_dim(cfg_width, LINE_W) * sat_dim(cfg_height, MAX_HEIGHT);
      if ($urandom_range(7) == 0) begin
        cut = $urandom_range(full - 1, 1);
        push_pixels(cut, style);
        settle();
        if ($urandom_range(1)) cfg_write(REG_WIDTH, pick_dim(14));
        else cfg_write(REG_HEIGHT, pick_dim(9));
        full = cut + pixels_left();
        push_pixels(full - cut, style);
      end else begin
        push_pixels(full, style);
      end
      random_pixels += full;
      frame_no++;
    end

    settle();
    $display("%0d pixels in, %0d medians checked, %0d frames closed, %0d register writes",
             pixels_in, medians_checked, frames_closed, cfg_writes);
    $display("reset geometry, size registers past both ends, mid-frame resizes, four flow mixes");
    if (errors == 0 && pending_medians.size() == 0) begin
      $display("median_filter_3x3: match");
    end else begin
      $display("median_filter_3x3: mismatch");
    end
    $finish;
  end

endmodule

FILE: median_filter_3x3.f
design/mf3_pkg.sv
design/mf3_col_cell.sv
design/mf3_line_buf.sv
design/mf3_median.sv
design/median_filter_3x3.sv
sim/median_filter_3x3_tb.sv
